// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the axis controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: hw/rtl/shac_pkg.sv
// Package with the types, codes and widths of the stepper axis homing controller.
`default_nettype none

package shac_pkg;

  // Field and datapath widths.
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned RATE_BITS  = 24;
  localparam int unsigned DT_BITS    = 16;
  localparam int unsigned STEP_BITS  = 16;
  localparam int unsigned PROD_BITS  = RATE_BITS + DT_BITS;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned SPAN_BITS  = 31;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Operating modes.
  localparam logic [2:0] MODE_UNHOMED = 3'd0;
  localparam logic [2:0] MODE_HOMING  = 3'd1;
  localparam logic [2:0] MODE_RUN     = 3'd2;
  localparam logic [2:0] MODE_HOLD    = 3'd3;
  localparam logic [2:0] MODE_FAULT   = 3'd4;

  // Homing phases.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_SEEK_FWD = 2'd1;
  localparam logic [1:0] PH_SEEK_REV = 2'd2;
  localparam logic [1:0] PH_CENTER   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_TRAVEL   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TRAVEL   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RUN_RATE     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOMING_RATE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOMING_TMO   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPAN     = 3'd5;

  // One control tick request.
  typedef struct packed {
    logic                        home_request;
    logic                        enable_request;
    logic                        fault_request;
    logic                        fwd_limit_pressed;
    logic                        rev_limit_pressed;
    logic signed [POS_BITS-1:0]  target_position;
    logic [DT_BITS-1:0]          elapsed_us;
  } shac_in_t;

  // One control tick result.
  typedef struct packed {
    logic [2:0]                  mode;
    logic                        is_homed;
    logic                        home_fail;
    logic signed [POS_BITS-1:0]  position;
    logic signed [POS_BITS-1:0]  target_out;
    logic                        motor_enable;
    logic                        moving;
    logic                        direction_forward;
    logic [STEP_BITS-1:0]        steps_issued;
    logic                        fwd_limit_echo;
    logic                        rev_limit_echo;
  } shac_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/stepper_axis_homing_controller.sv
// Stepper axis controller with limit-switch homing, run, hold and latched fault modes.
//
// Usage: every input request is one control tick carrying the commands, the two
// limit switches, a step target and the microseconds since the previous tick.
// Each tick produces exactly one result with the mode, position and the steps
// issued for that tick. Both data channels use valid/stall; a request moves at a
// clock edge where valid is high and stall is low. Registers are written over the
// cfg channel (index and data), which is always ready; the user must write them
// only while the block is idle, which the block itself does not enforce. The input
// register takes the tick and forms both rate-times-time products; the mode logic
// then runs on the registered tick and loads the result register. Throughput is one
// tick per cycle while the receiver does not stall, set by the single pass through
// the state update logic. When the receiver stalls, the result register holds; one
// more tick is still taken into the input register, after which in_stall_o rises.
// Reset clears all mode, position and homing state and all configuration registers
// to zero; the block accepts requests as soon as reset is released.
`default_nettype none

`include "assert_macros.svh"

module stepper_axis_homing_controller (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output      logic                                   in_stall_o,
  input  wire shac_pkg::shac_in_t                     in_item_i,
  output      logic                                   out_valid_o,
  input  wire logic                                   out_stall_i,
  output      shac_pkg::shac_out_t                    out_item_o,
  input  wire logic                                   cfg_valid_i,
  output      logic                                   cfg_ready_o,
  input  wire logic [shac_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [shac_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);
  import shac_pkg::*;

  typedef struct packed {
    logic [STEP_BITS-1:0] steps;
    logic [FRAC_BITS-1:0] frac;
  } budget_t;

  // Configuration registers.
  logic signed [POS_BITS-1:0]  min_travel_q, max_travel_q;
  logic [RATE_BITS-1:0]        run_rate_q, home_rate_q;
  logic [TIME_BITS-1:0]        timeout_q;
  logic [SPAN_BITS-1:0]        min_span_q;

  // Input stage.
  logic                        s1_valid_q, s1_valid_d;
  shac_in_t                    s1_item_q;
  logic [PROD_BITS-1:0]        prod_run_q, prod_home_q;
  logic                        in_accept, advance;

  // Output stage.
  logic                        out_valid_q, out_valid_d;
  shac_out_t                   out_q, out_d;

  // Axis state.
  logic [2:0]                  mode_q, mode_d;
  logic [1:0]                  phase_q, phase_d;
  logic                        homed_q, homed_d;
  logic                        fail_q, fail_d;
  logic                        prev_home_q, prev_home_d;
  logic [FRAC_BITS-1:0]        frac_q, frac_d;
  logic [TIME_BITS-1:0]        helapsed_q, helapsed_d;
  logic signed [POS_BITS-1:0]  pos_q, pos_d;
  logic signed [POS_BITS-1:0]  tgt_q, tgt_d;
  logic signed [POS_BITS-1:0]  fwd_hit_q, fwd_hit_d;
  logic signed [POS_BITS-1:0]  rev_hit_q, rev_hit_d;
  logic signed [POS_BITS-1:0]  center_q, center_d;

  // Working signals of the tick logic.
  logic signed [POS_BITS-1:0]  travel_lo, travel_hi, tgt_clamped, tgt_out;
  logic                        rise, motor, moving, dirf;
  logic [STEP_BITS-1:0]        count, step_n;
  budget_t                     bud;
  logic [TIME_BITS:0]          helapsed_sum;
  logic signed [POS_BITS:0]    diff, room, span;
  logic [POS_BITS:0]           abs_diff;

  // Fixed-point step budget; a zero product leaves the fraction alone.
  function automatic budget_t calc_budget(input logic [PROD_BITS-1:0] prod,
                                          input logic [FRAC_BITS-1:0] frac);
    logic [PROD_BITS:0]           total;
    logic [PROD_BITS-FRAC_BITS:0] whole;
    budget_t                      res;
    total = {1'b0, prod} + {{(PROD_BITS + 1 - FRAC_BITS){1'b0}}, frac};
    whole = total[PROD_BITS:FRAC_BITS];
    if (prod == '0) begin
      res.steps = '0;
      res.frac  = frac;
    end else begin
      res.steps = (|whole[PROD_BITS-FRAC_BITS:STEP_BITS]) ? {STEP_BITS{1'b1}}
                                                         : whole[STEP_BITS-1:0];
      res.frac  = total[FRAC_BITS-1:0];
    end
    return res;
  endfunction

  // Handshakes: the input register moves on whenever the output register is free.
  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Travel limits, swapped when they are entered in reverse, and the target clamped to them.
  always_comb begin
    if (min_travel_q > max_travel_q) begin
      travel_lo = max_travel_q;
      travel_hi = min_travel_q;
    end else begin
      travel_lo = min_travel_q;
      travel_hi = max_travel_q;
    end
    if (s1_item_q.target_position < travel_lo) begin
      tgt_clamped = travel_lo;
    end else if (s1_item_q.target_position > travel_hi) begin
      tgt_clamped = travel_hi;
    end else begin
      tgt_clamped = s1_item_q.target_position;
    end
  end

  // Tick logic: mode changes, homing sequence and run motion for one request.
  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    homed_d      = homed_q;
    fail_d       = fail_q;
    frac_d       = frac_q;
    helapsed_d   = helapsed_q;
    pos_d        = pos_q;
    tgt_d        = tgt_q;
    fwd_hit_d    = fwd_hit_q;
    rev_hit_d    = rev_hit_q;
    center_d     = center_q;
    motor        = 1'b0;
    moving       = 1'b0;
    dirf         = 1'b0;
    count        = '0;
    bud          = '0;
    step_n       = '0;
    helapsed_sum = '0;
    diff         = '0;
    room         = '0;
    span         = '0;
    abs_diff     = '0;
    tgt_out      = tgt_clamped;

    prev_home_d = s1_item_q.home_request;
    rise        = s1_item_q.home_request && !prev_home_q;
    if (s1_item_q.fault_request) begin
      mode_d = MODE_FAULT;
    end

    if (mode_d != MODE_FAULT) begin
      // A rising home command restarts homing from the current position.
      if (rise) begin
        mode_d     = MODE_HOMING;
        phase_d    = PH_SEEK_FWD;
        helapsed_d = '0;
        frac_d     = '0;
        homed_d    = 1'b0;
        fail_d     = 1'b0;
        fwd_hit_d  = pos_q;
        rev_hit_d  = pos_q;
        center_d   = pos_q;
      end

      // Run and hold follow the enable command once homed.
      case (mode_d)
        MODE_UNHOMED: begin
          if (s1_item_q.enable_request && homed_d) mode_d = MODE_RUN;
        end
        MODE_RUN: begin
          if (!s1_item_q.enable_request) mode_d = MODE_HOLD;
        end
        MODE_HOLD: begin
          if (s1_item_q.enable_request && homed_d) mode_d = MODE_RUN;
        end
        default: begin
        end
      endcase

      tgt_d = tgt_clamped;

      // Homing timer saturates and trips the timeout.
      if (mode_d == MODE_HOMING) begin
        helapsed_sum = {1'b0, helapsed_d} + {{(TIME_BITS + 1 - DT_BITS){1'b0}},
                                             s1_item_q.elapsed_us};
        helapsed_d   = helapsed_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                               : helapsed_sum[TIME_BITS-1:0];
        if ((timeout_q != '0) && (helapsed_d > timeout_q)) begin
          fail_d  = 1'b1;
          homed_d = 1'b0;
          mode_d  = MODE_UNHOMED;
          phase_d = PH_IDLE;
        end
      end

      if (mode_d == MODE_HOMING) begin
        bud    = calc_budget(prod_home_q, frac_d);
        frac_d = bud.frac;
        motor  = 1'b1;
        case (phase_d)
          PH_SEEK_FWD: begin
            if (s1_item_q.fwd_limit_pressed) begin
              fwd_hit_d = pos_q;
              phase_d   = PH_SEEK_REV;
            end else if (bud.steps != '0) begin
              dirf   = 1'b1;
              count  = bud.steps;
              moving = 1'b1;
              pos_d  = pos_q + $signed({{(POS_BITS - STEP_BITS){1'b0}}, bud.steps});
            end
          end
          PH_SEEK_REV: begin
            if (s1_item_q.rev_limit_pressed) begin
              rev_hit_d = pos_q;
              span      = {fwd_hit_d[POS_BITS-1], fwd_hit_d} - {pos_q[POS_BITS-1], pos_q};
              if (span <= $signed({2'b00, min_span_q})) begin
                fail_d  = 1'b1;
                homed_d = 1'b0;
                mode_d  = MODE_UNHOMED;
                phase_d = PH_IDLE;
              end else begin
                // The span is positive here, so halving is a plain shift.
                center_d = pos_q + $signed(span[POS_BITS:1]);
                phase_d  = PH_CENTER;
              end
            end else if (bud.steps != '0) begin
              dirf   = 1'b0;
              count  = bud.steps;
              moving = 1'b1;
              pos_d  = pos_q - $signed({{(POS_BITS - STEP_BITS){1'b0}}, bud.steps});
            end
          end
          PH_CENTER: begin
            diff     = {center_d[POS_BITS-1], center_d} - {pos_q[POS_BITS-1], pos_q};
            abs_diff = diff[POS_BITS] ? (POS_BITS + 1)'(0) - diff : diff;
            if (diff == '0) begin
              pos_d   = '0;
              tgt_d   = '0;
              homed_d = 1'b1;
              phase_d = PH_IDLE;
              mode_d  = s1_item_q.enable_request ? MODE_RUN : MODE_HOLD;
            end else if (bud.steps != '0) begin
              step_n = ({{(POS_BITS + 1 - STEP_BITS){1'b0}}, bud.steps} > abs_diff)
                       ? abs_diff[STEP_BITS-1:0] : bud.steps;
              dirf   = !diff[POS_BITS];
              count  = step_n;
              moving = step_n != '0;
              if (dirf) begin
                pos_d = pos_q + $signed({{(POS_BITS - STEP_BITS){1'b0}}, step_n});
              end else begin
                pos_d = pos_q - $signed({{(POS_BITS - STEP_BITS){1'b0}}, step_n});
              end
            end
          end
          default: begin
          end
        endcase
      end else if (mode_d == MODE_RUN) begin
        // Step toward the target unless the switch ahead is pressed.
        diff     = {tgt_d[POS_BITS-1], tgt_d} - {pos_q[POS_BITS-1], pos_q};
        abs_diff = diff[POS_BITS] ? (POS_BITS + 1)'(0) - diff : diff;
        motor    = 1'b1;
        if (diff != '0) begin
          if (!((!diff[POS_BITS] && s1_item_q.fwd_limit_pressed) ||
                (diff[POS_BITS] && s1_item_q.rev_limit_pressed))) begin
            bud    = calc_budget(prod_run_q, frac_d);
            frac_d = bud.frac;
            if (bud.steps != '0) begin
              step_n = ({{(POS_BITS + 1 - STEP_BITS){1'b0}}, bud.steps} > abs_diff)
                       ? abs_diff[STEP_BITS-1:0] : bud.steps;
              if (!diff[POS_BITS]) begin
                room = {travel_hi[POS_BITS-1], travel_hi} - {pos_q[POS_BITS-1], pos_q};
              end else begin
                room = {pos_q[POS_BITS-1], pos_q} - {travel_lo[POS_BITS-1], travel_lo};
              end
              if (room[POS_BITS] || (room == '0)) begin
                step_n = '0;
              end else if ({{(POS_BITS + 1 - STEP_BITS){1'b0}}, step_n} > room) begin
                step_n = room[STEP_BITS-1:0];
              end
              dirf   = !diff[POS_BITS];
              count  = step_n;
              moving = step_n != '0;
              if (dirf) begin
                pos_d = pos_q + $signed({{(POS_BITS - STEP_BITS){1'b0}}, step_n});
              end else begin
                pos_d = pos_q - $signed({{(POS_BITS - STEP_BITS){1'b0}}, step_n});
              end
            end
          end
        end
      end

      tgt_out = tgt_d;
      if (mode_d inside {MODE_UNHOMED, MODE_HOLD}) begin
        motor  = 1'b0;
        moving = 1'b0;
        count  = '0;
      end
    end
  end

  // Result assembly.
  always_comb begin
    out_d.mode              = mode_d;
    out_d.is_homed          = homed_d;
    out_d.home_fail         = fail_d;
    out_d.position          = pos_d;
    out_d.target_out        = tgt_out;
    out_d.motor_enable      = motor;
    out_d.moving            = moving;
    out_d.direction_forward = dirf;
    out_d.steps_issued      = count;
    out_d.fwd_limit_echo    = s1_item_q.fwd_limit_pressed;
    out_d.rev_limit_echo    = s1_item_q.rev_limit_pressed;
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_travel_q <= '0;
      max_travel_q <= '0;
      run_rate_q   <= '0;
      home_rate_q  <= '0;
      timeout_q    <= '0;
      min_span_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_TRAVEL:  min_travel_q <= $signed(cfg_data_i[POS_BITS-1:0]);
        REG_MAX_TRAVEL:  max_travel_q <= $signed(cfg_data_i[POS_BITS-1:0]);
        REG_RUN_RATE:    run_rate_q   <= cfg_data_i[RATE_BITS-1:0];
        REG_HOMING_RATE: home_rate_q  <= cfg_data_i[RATE_BITS-1:0];
        REG_HOMING_TMO:  timeout_q    <= cfg_data_i[TIME_BITS-1:0];
        REG_MIN_SPAN:    min_span_q   <= cfg_data_i[SPAN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register with both rate products formed on the way in.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q   <= in_item_i;
      prod_run_q  <= {{DT_BITS{1'b0}}, run_rate_q} *
                     {{RATE_BITS{1'b0}}, in_item_i.elapsed_us};
      prod_home_q <= {{DT_BITS{1'b0}}, home_rate_q} *
                     {{RATE_BITS{1'b0}}, in_item_i.elapsed_us};
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Axis state, updated once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNHOMED;
      phase_q     <= PH_IDLE;
      homed_q     <= 1'b0;
      fail_q      <= 1'b0;
      prev_home_q <= 1'b0;
      frac_q      <= '0;
      helapsed_q  <= '0;
      pos_q       <= '0;
      tgt_q       <= '0;
      fwd_hit_q   <= '0;
      rev_hit_q   <= '0;
      center_q    <= '0;
    end else if (advance) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      homed_q     <= homed_d;
      fail_q      <= fail_d;
      prev_home_q <= prev_home_d;
      frac_q      <= frac_d;
      helapsed_q  <= helapsed_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
      fwd_hit_q   <= fwd_hit_d;
      rev_hit_q   <= rev_hit_d;
      center_q    <= center_d;
    end
  end

  // Fault latches until reset.
  `ASSERT_NEXT(a_fault_sticky, mode_q == MODE_FAULT, mode_q == MODE_FAULT)
  // Homing always runs in a real phase and never with the homed flag set.
  `ASSERT_IMPLIES(a_homing_phase, mode_q == MODE_HOMING, (phase_q != PH_IDLE) && !homed_q)
  // A live homing phase exists only while homing or frozen by a fault.
  `ASSERT_IMPLIES(a_phase_mode, phase_q != PH_IDLE,
                  (mode_q == MODE_HOMING) || (mode_q == MODE_FAULT))
  // A processed tick always leaves a result in the output register.
  `ASSERT_NEXT(a_advance_result, advance, out_valid_q)

endmodule

`default_nettype wire

// File: dv/stepper_axis_homing_controller_tb.sv
// Testbench for the stepper axis homing controller: random requests, predicted results.
`default_nettype none

module stepper_axis_homing_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shac_pkg::*;

  // Clock, reset and block ports.
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  shac_in_t  in_item = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  shac_out_t out_item_o;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  stepper_axis_homing_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be sent and results waiting to arrive.
  shac_in_t  tick_queue[$];
  shac_out_t status_due[$];
  int        ticks_queued = 0;
  int        mismatches = 0;
  int        results_seen = 0;

  // Axis model: configuration copy.
  longint lim_min = 0, lim_max = 0;
  longint rate_run_cfg = 0, rate_home_cfg = 0, tmo_cfg = 0, span_cfg = 0;

  // Axis model: state, all zero after reset.
  logic [2:0] mode_m = MODE_UNHOMED;
  logic [1:0] phase_m = PH_IDLE;
  bit         homed_m = 1'b0, fail_m = 1'b0, prev_home = 1'b0;
  longint     frac_m = 0, home_time = 0;
  longint     pos_m = 0, tgt_m = 0, fwd_hit = 0, rev_hit = 0, center_m = 0;

  // Wrap a position to 32-bit two's complement.
  function automatic longint wrap_pos(longint v);
    logic signed [POS_BITS-1:0] w;
    w = v[POS_BITS-1:0];
    return longint'(w);
  endfunction

  // Travel limits in ascending order, whatever order they were written in.
  function automatic void travel_bounds(output longint lo, output longint hi);
    lo = (lim_min > lim_max) ? lim_max : lim_min;
    hi = (lim_min > lim_max) ? lim_min : lim_max;
  endfunction

  function automatic longint clamp_to_travel(longint t);
    longint lo, hi;
    travel_bounds(lo, hi);
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t;
  endfunction

  // Fixed-point step budget; the fractional remainder carries to the next tick.
  function automatic longint draw_steps(longint rate, longint dt);
    longint total, whole;
    if (rate == 0 || dt == 0) return 0;
    total = rate * dt + frac_m;
    whole = total >> FRAC_BITS;
    frac_m = total & ((longint'(1) << FRAC_BITS) - 1);
    return (whole > 65535) ? 65535 : whole;
  endfunction

  function automatic void abort_homing();
    fail_m = 1'b1;
    homed_m = 1'b0;
    mode_m = MODE_UNHOMED;
    phase_m = PH_IDLE;
  endfunction

  // Advance the axis model by one tick and return the result it should produce.
  function automatic shac_out_t step_axis_model(shac_in_t req);
    shac_out_t res;
    bit        rise, motor, moving, fwd_dir, heading_fwd;
    longint    tgt_in, tgt_shown, dt, budget, d, s, span, room, lo, hi;
    rise = req.home_request && !prev_home;
    motor = 1'b0;
    moving = 1'b0;
    fwd_dir = 1'b0;
    s = 0;
    tgt_in = longint'($signed(req.target_position));
    dt = longint'(req.elapsed_us);
    prev_home = req.home_request;
    if (req.fault_request) mode_m = MODE_FAULT;

    if (mode_m == MODE_FAULT) begin
      tgt_shown = clamp_to_travel(tgt_in);
    end else begin
      if (rise) begin
        mode_m = MODE_HOMING;
        phase_m = PH_SEEK_FWD;
        home_time = 0;
        frac_m = 0;
        homed_m = 1'b0;
        fail_m = 1'b0;
        fwd_hit = pos_m;
        rev_hit = pos_m;
        center_m = pos_m;
      end
      // Run and hold follow the enable request once the axis is homed.
      if (mode_m == MODE_UNHOMED && req.enable_request && homed_m) mode_m = MODE_RUN;
      else if (mode_m == MODE_RUN && !req.enable_request) mode_m = MODE_HOLD;
      else if (mode_m == MODE_HOLD && req.enable_request && homed_m) mode_m = MODE_RUN;

      tgt_m = clamp_to_travel(tgt_in);

      // Homing timer saturates and fails homing once past a nonzero limit.
      if (mode_m == MODE_HOMING) begin
        home_time += dt;
        if (home_time > 64'hFFFF_FFFF) home_time = 64'hFFFF_FFFF;
        if (tmo_cfg != 0 && home_time > tmo_cfg) abort_homing();
      end

      if (mode_m == MODE_HOMING) begin
        budget = draw_steps(rate_home_cfg, dt);
        motor = 1'b1;
        case (phase_m)
          PH_SEEK_FWD: begin
            if (req.fwd_limit_pressed) begin
              fwd_hit = pos_m;
              phase_m = PH_SEEK_REV;
            end else if (budget > 0) begin
              fwd_dir = 1'b1;
              s = budget;
              moving = 1'b1;
              pos_m = wrap_pos(pos_m + budget);
            end
          end
          PH_SEEK_REV: begin
            if (req.rev_limit_pressed) begin
              rev_hit = pos_m;
              span = fwd_hit - rev_hit;
              if (span <= span_cfg) begin
                abort_homing();
              end else begin
                center_m = rev_hit + span / 2;
                phase_m = PH_CENTER;
              end
            end else if (budget > 0) begin
              s = budget;
              moving = 1'b1;
              pos_m = wrap_pos(pos_m - budget);
            end
          end
          PH_CENTER: begin
            d = center_m - pos_m;
            if (d == 0) begin
              pos_m = 0;
              tgt_m = 0;
              homed_m = 1'b1;
              phase_m = PH_IDLE;
              mode_m = req.enable_request ? MODE_RUN : MODE_HOLD;
            end else if (budget > 0) begin
              s = (d > 0) ? d : -d;
              if (s > budget) s = budget;
              fwd_dir = (d > 0);
              moving = (s > 0);
              pos_m = wrap_pos(fwd_dir ? pos_m + s : pos_m - s);
            end
          end
          default: ;
        endcase
      end else if (mode_m == MODE_RUN) begin
        // Step toward the target unless the switch ahead is pressed.
        d = tgt_m - pos_m;
        motor = 1'b1;
        if (d != 0) begin
          heading_fwd = (d > 0);
          if (!((heading_fwd && req.fwd_limit_pressed) ||
                (!heading_fwd && req.rev_limit_pressed))) begin
            s = draw_steps(rate_run_cfg, dt);
            if (s != 0) begin
              travel_bounds(lo, hi);
              if (s > ((d > 0) ? d : -d)) s = (d > 0) ? d : -d;
              room = heading_fwd ? hi - pos_m : pos_m - lo;
              if (room <= 0) s = 0;
              else if (s > room) s = room;
              fwd_dir = heading_fwd;
              moving = (s > 0);
              pos_m = wrap_pos(heading_fwd ? pos_m + s : pos_m - s);
            end
          end
        end
      end
      tgt_shown = tgt_m;
      if (mode_m == MODE_UNHOMED || mode_m == MODE_HOLD) begin
        motor = 1'b0;
        moving = 1'b0;
        s = 0;
      end
    end

    res.mode = mode_m;
    res.is_homed = homed_m;
    res.home_fail = fail_m;
    res.position = pos_m[POS_BITS-1:0];
    res.target_out = tgt_shown[POS_BITS-1:0];
    res.motor_enable = motor;
    res.moving = moving;
    res.direction_forward = fwd_dir;
    res.steps_issued = s[STEP_BITS-1:0];
    res.fwd_limit_echo = req.fwd_limit_pressed;
    res.rev_limit_echo = req.rev_limit_pressed;
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int       burst_left = 0;
  int       gap_left = 0;
  bit       offer;
  shac_in_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      next_req = in_item;
      if (in_valid && !in_stall_o) begin
        status_due.push_back(step_axis_model(in_item));
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
          burst_left = $urandom_range(1, 16);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_queue.size() != 0) begin
          next_req = tick_queue.pop_front();
          offer = 1'b1;
        end
      end
      in_valid <= offer;
      in_item <= next_req;
    end
  end

  // Result monitor with its own stall pattern and one long hold-off.
  int        stall_style = 0;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;
  bit        stall_next;
  shac_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (status_due.size() == 0) begin
          flag_mismatch("unexpected result", 0, 0);
        end else begin
          want = status_due.pop_front();
          if (out_item_o.mode !== want.mode)
            flag_mismatch("mode", out_item_o.mode, want.mode);
          if (out_item_o.is_homed !== want.is_homed)
            flag_mismatch("is_homed", out_item_o.is_homed, want.is_homed);
          if (out_item_o.home_fail !== want.home_fail)
            flag_mismatch("home_fail", out_item_o.home_fail, want.home_fail);
          if (out_item_o.position !== want.position)
            flag_mismatch("position", $signed(out_item_o.position), $signed(want.position));
          if (out_item_o.target_out !== want.target_out)
            flag_mismatch("target_out", $signed(out_item_o.target_out),
                          $signed(want.target_out));
          if (out_item_o.motor_enable !== want.motor_enable)
            flag_mismatch("motor_enable", out_item_o.motor_enable, want.motor_enable);
          if (out_item_o.moving !== want.moving)
            flag_mismatch("moving", out_item_o.moving, want.moving);
          if (out_item_o.direction_forward !== want.direction_forward)
            flag_mismatch("direction_forward", out_item_o.direction_forward,
                          want.direction_forward);
          if (out_item_o.steps_issued !== want.steps_issued)
            flag_mismatch("steps_issued", out_item_o.steps_issued, want.steps_issued);
          if (out_item_o.fwd_limit_echo !== want.fwd_limit_echo)
            flag_mismatch("fwd_limit_echo", out_item_o.fwd_limit_echo, want.fwd_limit_echo);
          if (out_item_o.rev_limit_echo !== want.rev_limit_echo)
            flag_mismatch("rev_limit_echo", out_item_o.rev_limit_echo, want.rev_limit_echo);
        end
      end
      // Hold off once for a long stretch while requests keep coming.
      if (!long_hold_done && results_seen >= 60 && in_valid) begin
        long_hold_done = 1'b1;
        hold_left = 300;
      end
      if ($urandom_range(0, 63) == 0) stall_style = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_style)
          0: stall_next = 1'b0;
          1: stall_next = $urandom_range(0, 1);
          default: stall_next = ($urandom_range(0, 4) != 0);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // Write one register while the block is idle and mirror it into the model.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_TRAVEL:  lim_min = longint'($signed(value));
      REG_MAX_TRAVEL:  lim_max = longint'($signed(value));
      REG_RUN_RATE:    rate_run_cfg = longint'(value[RATE_BITS-1:0]);
      REG_HOMING_RATE: rate_home_cfg = longint'(value[RATE_BITS-1:0]);
      REG_HOMING_TMO:  tmo_cfg = longint'(value);
      REG_MIN_SPAN:    span_cfg = longint'(value[SPAN_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_axis_config(logic [31:0] lo, logic [31:0] hi, logic [31:0] run_rate,
                                 logic [31:0] home_rate, logic [31:0] tmo,
                                 logic [31:0] span);
    write_reg(REG_MIN_TRAVEL, lo);
    write_reg(REG_MAX_TRAVEL, hi);
    write_reg(REG_RUN_RATE, run_rate);
    write_reg(REG_HOMING_RATE, home_rate);
    write_reg(REG_HOMING_TMO, tmo);
    write_reg(REG_MIN_SPAN, span);
  endtask

  task automatic push_tick(bit home, bit en, bit fault, bit fwd, bit rev,
                           logic [31:0] target, logic [15:0] dt);
    shac_in_t t;
    t.home_request = home;
    t.enable_request = en;
    t.fault_request = fault;
    t.fwd_limit_pressed = fwd;
    t.rev_limit_pressed = rev;
    t.target_position = target;
    t.elapsed_us = dt;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // Targets mostly near the travel window, sometimes anywhere or at the extremes.
  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 16000)) - 8000;
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic bit rand_bit();
    return $urandom_range(0, 1);
  endfunction

  // A well-formed homing run: rising home, seek forward, seek reverse, center, then run.
  task automatic queue_homing_run(int max_seek);
    int n_fwd, n_rev;
    push_tick(1'b0, rand_bit(), 1'b0, rand_bit(), rand_bit(), rand_target(), rand_dt());
    push_tick(1'b1, rand_bit(), 1'b0, ($urandom_range(0, 9) == 0), rand_bit(),
              rand_target(), rand_dt());
    n_fwd = $urandom_range(0, max_seek);
    repeat (n_fwd)
      push_tick(1'b1, rand_bit(), 1'b0, 1'b0, rand_bit(), rand_target(), rand_dt());
    push_tick(1'b1, rand_bit(), 1'b0, 1'b1, rand_bit(), rand_target(), rand_dt());
    n_rev = $urandom_range(0, max_seek);
    repeat (n_rev)
      push_tick(1'b1, rand_bit(), 1'b0, rand_bit(), 1'b0, rand_target(), rand_dt());
    push_tick(1'b1, rand_bit(), 1'b0, rand_bit(), 1'b1, rand_target(), rand_dt());
    repeat (n_rev + 2)
      push_tick(1'b1, ($urandom_range(0, 7) != 0), 1'b0, 1'b0, 1'b0,
                rand_target(), rand_dt());
    // Run ticks; a dropped home level now and then restarts homing.
    repeat ($urandom_range(5, 30))
      push_tick(($urandom_range(0, 24) != 0), ($urandom_range(0, 6) != 0), 1'b0,
                ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) == 0),
                rand_target(), rand_dt());
  endtask

  // Fill one phase, mostly homing runs and some random ticks with no fault request.
  task automatic queue_phase(int n_items, int max_seek);
    int goal;
    @(negedge clk);
    goal = ticks_queued + n_items;
    while (ticks_queued < goal) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 10))
          push_tick(rand_bit(), rand_bit(), 1'b0, rand_bit(), rand_bit(),
                    $urandom, $urandom_range(0, 65535));
      end else begin
        queue_homing_run(max_seek);
      end
    end
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    logic [31:0] lo, hi;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unhomed ticks, a short-span failure, a full homing, run and hold.
    set_axis_config(-4000, 4000, 32'h01_8000, 32'h01_0000, 0, 10);
    @(negedge clk);
    push_tick(0, 1, 0, 1, 0, 32'h7FFF_FFFF, 16'd65535);
    push_tick(0, 1, 0, 0, 1, 32'h8000_0000, 16'd0);
    push_tick(1, 0, 0, 1, 0, 100, 16'd10);
    push_tick(1, 0, 0, 0, 1, 100, 16'd10);
    push_tick(0, 0, 0, 0, 0, 100, 16'd5);
    push_tick(1, 1, 0, 0, 0, -100, 16'd20);
    push_tick(1, 1, 0, 0, 1, 0, 16'd30);
    push_tick(1, 1, 0, 1, 0, 0, 16'd10);
    push_tick(1, 1, 0, 1, 0, 0, 16'd40);
    push_tick(1, 1, 0, 0, 0, 0, 16'd40);
    push_tick(1, 1, 0, 0, 1, 0, 16'd5);
    push_tick(1, 1, 0, 0, 0, 0, 16'd100);
    push_tick(1, 1, 0, 0, 0, 0, 16'd7);
    push_tick(1, 1, 0, 0, 0, 32'h7FFF_FFFF, 16'd1000);
    push_tick(1, 1, 0, 0, 0, 32'h8000_0000, 16'd65535);
    push_tick(1, 1, 0, 1, 0, 0, 16'd100);
    push_tick(1, 1, 0, 0, 1, 2000, 16'd100);
    push_tick(1, 0, 0, 0, 0, 1000, 16'd50);
    push_tick(1, 0, 0, 0, 0, 1000, 16'd65535);
    push_tick(1, 1, 0, 0, 0, 1000, 16'd3);
    push_tick(1, 1, 0, 0, 0, 1000, 16'd3);
    push_tick(1, 1, 0, 0, 0, 1000, 16'd0);
    push_tick(1, 1, 0, 0, 1, -4000, 16'd100);
    wait_drained();

    queue_phase(110, 10);
    wait_drained();

    // Reversed travel limits.
    set_axis_config(3000, -2500, 32'h00_4000, 32'h02_8000, 0, 0);
    queue_phase(90, 12);
    wait_drained();

    // Short timeout and a large minimum span: many homing failures.
    set_axis_config(-6000, 6000, 32'h03_0000, 32'h00_8000, $urandom_range(500, 3000), 400);
    queue_phase(80, 14);
    wait_drained();

    // Widest limits and fastest rates: step counts saturate.
    set_axis_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
                    32'hFFFF_FFFF, 0);
    queue_phase(90, 8);
    wait_drained();

    // No span can pass, zero run rate, zero-width travel window.
    set_axis_config(0, 0, 0, $urandom_range(1, 24'hFF_FFFF), 32'hFFFF_0000, 32'h7FFF_FFFF);
    queue_phase(50, 6);
    wait_drained();

    // Random moderate settings, limits in either order.
    lo = -int'($urandom_range(0, 8000));
    hi = $urandom_range(0, 8000);
    if (rand_bit()) set_axis_config(hi, lo, $urandom_range(1, 24'h0F_FFFF),
                                    $urandom_range(1, 24'h0F_FFFF),
                                    rand_bit() ? 0 : $urandom_range(1000, 50000),
                                    $urandom_range(0, 200));
    else set_axis_config(lo, hi, $urandom_range(1, 24'h0F_FFFF),
                         $urandom_range(1, 24'h0F_FFFF),
                         rand_bit() ? 0 : $urandom_range(1000, 50000),
                         $urandom_range(0, 200));
    queue_phase(110, 12);
    wait_drained();

    // Hard fault latches for the rest of the run; home edges are then ignored.
    @(negedge clk);
    push_tick(1, 1, 1, 0, 0, 32'h7FFF_FFFF, 16'd100);
    push_tick(0, 1, 0, 1, 0, 32'h8000_0000, 16'd65535);
    push_tick(1, 1, 0, 0, 1, 0, 16'd50);
    push_tick(1, 0, 0, 1, 1, 32'h7FFF_FFFF, 16'd0);
    repeat (6)
      push_tick(rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_bit(),
                rand_target(), rand_dt());
    wait_drained();
    repeat (6) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/shac_pkg.sv
hw/rtl/stepper_axis_homing_controller.sv
dv/stepper_axis_homing_controller_tb.sv
